// File: rtl/qrv_pkg.sv
// Shared types and constants for the quaternion vector rotation pipeline.
package qrv_pkg;

    localparam int DATA_W  = 16;               // vector and quaternion component width
    localparam int FRAC_W  = 15;               // quaternion fraction bits
    localparam int FR2     = 2 * FRAC_W;       // fraction bits of the exact sums
    localparam int P1_W    = 2 * DATA_W;       // q * v product
    localparam int UV_W    = P1_W + 1;         // q x v component
    localparam int P2_W    = DATA_W + UV_W;    // q * uv and w * uv products
    localparam int T_W     = P2_W + 2;         // w(q x v) + q x (q x v)
    localparam int ACC_W   = T_W + 2;          // v + 2t + half, full precision
    localparam int RES_W   = ACC_W - FR2;      // integer part after the shift
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_QUAT_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_QUAT_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_QUAT_Z = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_QUAT_W = 2'd3;

    localparam logic signed [DATA_W-1:0] QUAT_W_RESET = 16'sd32767;

    typedef struct packed {
        logic signed [DATA_W-1:0] vec_x;
        logic signed [DATA_W-1:0] vec_y;
        logic signed [DATA_W-1:0] vec_z;
    } t_vec_in;

    typedef struct packed {
        logic signed [DATA_W-1:0] rot_x;
        logic signed [DATA_W-1:0] rot_y;
        logic signed [DATA_W-1:0] rot_z;
        logic                     saturated;
    } t_rot_out;

    typedef struct packed {
        logic signed [DATA_W-1:0] x;
        logic signed [DATA_W-1:0] y;
        logic signed [DATA_W-1:0] z;
        logic signed [DATA_W-1:0] w;
    } t_quat;

    typedef struct packed {
        logic signed [UV_W-1:0] x;
        logic signed [UV_W-1:0] y;
        logic signed [UV_W-1:0] z;
    } t_uv;

    typedef struct packed {
        logic signed [T_W-1:0] x;
        logic signed [T_W-1:0] y;
        logic signed [T_W-1:0] z;
    } t_tvec;

    typedef struct packed {
        logic signed [DATA_W-1:0] val;
        logic                     clip;
    } t_sat;

endpackage

// File: rtl/qrv_cross1.sv
// First cross product q x v: product stage, then difference stage.
module qrv_cross1 (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  qrv_pkg::t_vec_in i_vec,
    input  qrv_pkg::t_quat  i_quat,
    output logic            o_valid,
    input  logic            i_ready,
    output qrv_pkg::t_uv    o_uv,
    output qrv_pkg::t_vec_in o_vec
);

    logic                                 r_va, r_vb;
    logic                                 w_ready_a, w_ready_b;
    logic signed [qrv_pkg::P1_W-1:0]      r_p [6];
    logic signed [qrv_pkg::P1_W-1:0]      n_p [6];
    qrv_pkg::t_vec_in                     r_vec_a, r_vec_b;
    qrv_pkg::t_uv                         r_uv, n_uv;

    assign w_ready_b = !r_vb || i_ready;
    assign w_ready_a = !r_va || w_ready_b;
    assign o_ready   = w_ready_a;

    always_comb begin
        n_p[0] = i_quat.y * i_vec.vec_z;
        n_p[1] = i_quat.z * i_vec.vec_y;
        n_p[2] = i_quat.z * i_vec.vec_x;
        n_p[3] = i_quat.x * i_vec.vec_z;
        n_p[4] = i_quat.x * i_vec.vec_y;
        n_p[5] = i_quat.y * i_vec.vec_x;
        n_uv.x = qrv_pkg::UV_W'(r_p[0]) - qrv_pkg::UV_W'(r_p[1]);
        n_uv.y = qrv_pkg::UV_W'(r_p[2]) - qrv_pkg::UV_W'(r_p[3]);
        n_uv.z = qrv_pkg::UV_W'(r_p[4]) - qrv_pkg::UV_W'(r_p[5]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
        end else begin
            if (w_ready_a) r_va <= i_valid;
            if (w_ready_b) r_vb <= r_va;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ready_a && i_valid) begin
            r_p     <= n_p;
            r_vec_a <= i_vec;
        end
        if (w_ready_b && r_va) begin
            r_uv    <= n_uv;
            r_vec_b <= r_vec_a;
        end
    end

    assign o_valid = r_vb;
    assign o_uv    = r_uv;
    assign o_vec   = r_vec_b;

endmodule

// File: rtl/qrv_cross2.sv
// Second cross product q x (q x v) and the w term: product stage, then sum stage.
module qrv_cross2 (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  qrv_pkg::t_uv     i_uv,
    input  qrv_pkg::t_vec_in i_vec,
    input  qrv_pkg::t_quat   i_quat,
    output logic             o_valid,
    input  logic             i_ready,
    output qrv_pkg::t_tvec   o_t,
    output qrv_pkg::t_vec_in o_vec
);

    logic                                 r_va, r_vb;
    logic                                 w_ready_a, w_ready_b;
    logic signed [qrv_pkg::P2_W-1:0]      r_c [6];
    logic signed [qrv_pkg::P2_W-1:0]      n_c [6];
    logic signed [qrv_pkg::P2_W-1:0]      r_w [3];
    logic signed [qrv_pkg::P2_W-1:0]      n_w [3];
    qrv_pkg::t_vec_in                     r_vec_a, r_vec_b;
    qrv_pkg::t_tvec                       r_t, n_t;

    assign w_ready_b = !r_vb || i_ready;
    assign w_ready_a = !r_va || w_ready_b;
    assign o_ready   = w_ready_a;

    always_comb begin
        n_c[0] = i_quat.y * i_uv.z;
        n_c[1] = i_quat.z * i_uv.y;
        n_c[2] = i_quat.z * i_uv.x;
        n_c[3] = i_quat.x * i_uv.z;
        n_c[4] = i_quat.x * i_uv.y;
        n_c[5] = i_quat.y * i_uv.x;
        n_w[0] = i_quat.w * i_uv.x;
        n_w[1] = i_quat.w * i_uv.y;
        n_w[2] = i_quat.w * i_uv.z;
        // t = w(q x v) + q x (q x v), exact at 2*FRAC_W fraction bits
        n_t.x = qrv_pkg::T_W'(r_w[0]) + qrv_pkg::T_W'(r_c[0]) - qrv_pkg::T_W'(r_c[1]);
        n_t.y = qrv_pkg::T_W'(r_w[1]) + qrv_pkg::T_W'(r_c[2]) - qrv_pkg::T_W'(r_c[3]);
        n_t.z = qrv_pkg::T_W'(r_w[2]) + qrv_pkg::T_W'(r_c[4]) - qrv_pkg::T_W'(r_c[5]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
        end else begin
            if (w_ready_a) r_va <= i_valid;
            if (w_ready_b) r_vb <= r_va;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ready_a && i_valid) begin
            r_c     <= n_c;
            r_w     <= n_w;
            r_vec_a <= i_vec;
        end
        if (w_ready_b && r_va) begin
            r_t     <= n_t;
            r_vec_b <= r_vec_a;
        end
    end

    assign o_valid = r_vb;
    assign o_t     = r_t;
    assign o_vec   = r_vec_b;

endmodule

// File: rtl/qrv_round.sv
// Final stage: v + 2t, round to nearest, saturate, flag clipping; holds the output beat.
module qrv_round (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  qrv_pkg::t_tvec   i_t,
    input  qrv_pkg::t_vec_in i_vec,
    output logic             o_valid,
    input  logic             i_ready,
    output qrv_pkg::t_rot_out o_rot
);

    localparam logic signed [qrv_pkg::RES_W-1:0] RES_HI =
        qrv_pkg::RES_W'((64'sd1 <<< (qrv_pkg::DATA_W - 1)) - 64'sd1);
    localparam logic signed [qrv_pkg::RES_W-1:0] RES_LO =
        qrv_pkg::RES_W'(-(64'sd1 <<< (qrv_pkg::DATA_W - 1)));
    localparam logic signed [qrv_pkg::ACC_W-1:0] HALF =
        qrv_pkg::ACC_W'(64'sd1 <<< (qrv_pkg::FR2 - 1));

    logic              r_valid;
    logic              w_ready;
    qrv_pkg::t_rot_out r_rot, n_rot;
    qrv_pkg::t_sat     w_sx, w_sy, w_sz;

    function automatic qrv_pkg::t_sat round_sat(
        input logic signed [qrv_pkg::DATA_W-1:0] v,
        input logic signed [qrv_pkg::T_W-1:0]    t
    );
        logic signed [qrv_pkg::ACC_W-1:0] acc;
        logic signed [qrv_pkg::RES_W-1:0] res;
        qrv_pkg::t_sat                    s;
        acc = (qrv_pkg::ACC_W'(v) <<< qrv_pkg::FR2)
            + (qrv_pkg::ACC_W'(t) <<< 1) + HALF;
        res = acc[qrv_pkg::ACC_W-1:qrv_pkg::FR2];
        if (res > RES_HI) begin
            s.val  = RES_HI[qrv_pkg::DATA_W-1:0];
            s.clip = 1'b1;
        end else if (res < RES_LO) begin
            s.val  = RES_LO[qrv_pkg::DATA_W-1:0];
            s.clip = 1'b1;
        end else begin
            s.val  = res[qrv_pkg::DATA_W-1:0];
            s.clip = 1'b0;
        end
        return s;
    endfunction

    assign w_ready = !r_valid || i_ready;
    assign o_ready = w_ready;

    always_comb begin
        w_sx = round_sat(i_vec.vec_x, i_t.x);
        w_sy = round_sat(i_vec.vec_y, i_t.y);
        w_sz = round_sat(i_vec.vec_z, i_t.z);
        n_rot.rot_x     = w_sx.val;
        n_rot.rot_y     = w_sy.val;
        n_rot.rot_z     = w_sz.val;
        n_rot.saturated = w_sx.clip || w_sy.clip || w_sz.clip;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ready && i_valid) begin
            r_rot <= n_rot;
        end
    end

    assign o_valid = r_valid;
    assign o_rot   = r_rot;

    a_sat_at_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_rot.saturated) |->
            (r_rot.rot_x == RES_HI[qrv_pkg::DATA_W-1:0]
             || r_rot.rot_x == RES_LO[qrv_pkg::DATA_W-1:0]
             || r_rot.rot_y == RES_HI[qrv_pkg::DATA_W-1:0]
             || r_rot.rot_y == RES_LO[qrv_pkg::DATA_W-1:0]
             || r_rot.rot_z == RES_HI[qrv_pkg::DATA_W-1:0]
             || r_rot.rot_z == RES_LO[qrv_pkg::DATA_W-1:0]))
        else $error("saturated flag set with no component at a limit");

    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_valid |-> o_ready)
        else $error("empty output stage refuses a beat");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_valid)
        else $error("output valid after reset");

endmodule

// File: rtl/quaternion_rotate_vector.sv
// Top level: rotates a stream of 3-vectors by a configured fixed-point quaternion.
//
// Usage:
//   Input channel (i_vec_valid / o_vec_ready / i_vec) takes one signed 16-bit vector
//   per beat. Output channel (o_rot_valid / i_rot_ready / o_rot) delivers the rotated
//   vector, rounded to nearest and saturated to 16 bits, plus a flag that is set when
//   any component was clipped. Exactly one output beat per input beat, in order.
//   Configuration: write quat_x, quat_y, quat_z, quat_w (Q1.15) through i_cfg_we,
//   i_cfg_idx and i_cfg_data, one register per cycle, while the pipeline is empty.
//   Throughput: one vector per cycle, sustained, while the receiver takes beats.
//   Pipeline: five register stages, namely the two multiplier ranks of the two cross
//   products, their sum stages and the final round and saturate stage, which is
//   also the output register.
//   Stall: each stage advances only when the one after it is empty or moving, so a
//   stalled receiver holds the output beat and bubbles fill up behind it; input ready
//   drops only once all five stages are occupied.
//   Reset (synchronous, active low): empty the pipeline and return the quaternion
//   to the identity (0, 0, 0, 32767).
module quaternion_rotate_vector (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_vec_valid,
    output logic                            o_vec_ready,
    input  qrv_pkg::t_vec_in                i_vec,
    output logic                            o_rot_valid,
    input  logic                            i_rot_ready,
    output qrv_pkg::t_rot_out               o_rot,
    input  logic                            i_cfg_we,
    input  logic [qrv_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [qrv_pkg::DATA_W-1:0]      i_cfg_data
);

    qrv_pkg::t_quat   r_quat;

    logic             w_c1_valid, w_c1_ready;
    qrv_pkg::t_uv     w_c1_uv;
    qrv_pkg::t_vec_in w_c1_vec;
    logic             w_c2_valid, w_c2_ready;
    qrv_pkg::t_tvec   w_c2_t;
    qrv_pkg::t_vec_in w_c2_vec;

    // Configuration registers: take a write as it comes, no handshake.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quat.x <= '0;
            r_quat.y <= '0;
            r_quat.z <= '0;
            r_quat.w <= qrv_pkg::QUAT_W_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                qrv_pkg::REG_QUAT_X: r_quat.x <= i_cfg_data;
                qrv_pkg::REG_QUAT_Y: r_quat.y <= i_cfg_data;
                qrv_pkg::REG_QUAT_Z: r_quat.z <= i_cfg_data;
                qrv_pkg::REG_QUAT_W: r_quat.w <= i_cfg_data;
                default: r_quat <= r_quat;
            endcase
        end
    end

    // q x v
    qrv_cross1 u_cross1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_vec_valid),
        .o_ready (o_vec_ready),
        .i_vec   (i_vec),
        .i_quat  (r_quat),
        .o_valid (w_c1_valid),
        .i_ready (w_c1_ready),
        .o_uv    (w_c1_uv),
        .o_vec   (w_c1_vec)
    );

    // w(q x v) + q x (q x v)
    qrv_cross2 u_cross2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_c1_valid),
        .o_ready (w_c1_ready),
        .i_uv    (w_c1_uv),
        .i_vec   (w_c1_vec),
        .i_quat  (r_quat),
        .o_valid (w_c2_valid),
        .i_ready (w_c2_ready),
        .o_t     (w_c2_t),
        .o_vec   (w_c2_vec)
    );

    // v + 2t, round, saturate; hold the beat for the receiver
    qrv_round u_round (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_c2_valid),
        .o_ready (w_c2_ready),
        .i_t     (w_c2_t),
        .i_vec   (w_c2_vec),
        .o_valid (o_rot_valid),
        .i_ready (i_rot_ready),
        .o_rot   (o_rot)
    );

endmodule
